// ----- design/stmc_pkg.sv -----
// Shared types and constants for the servo tester mode controller.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package stmc_pkg;

  // Behavior constants
  localparam int SWEEP_HALF_MS = 1500;
  localparam int MAX_ANGLE     = 180;

  // Field widths
  localparam int ANGLE_W   = 8;
  localparam int PULSE_W   = 12;
  localparam int MINP_W    = 11;
  localparam int LIMIT_W   = 13;
  localparam int MV_W      = 14;
  localparam int SCALE_W   = 18;
  localparam int BEEP_W    = 16;
  localparam int TIME_W    = 32;
  localparam int RAW_W     = 12;
  localparam int CUR_W     = 13;
  localparam int DELTA_W   = 5;
  localparam int CURSOR_W  = 3;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 18;
  localparam logic [CFG_INDEX_W-1:0] CFG_MV_SCALE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_MV    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BEEP_HALF = 2'd2;

  localparam logic [SCALE_W-1:0] MV_SCALE_RST  = 18'd105627;
  localparam logic [MV_W-1:0]    LOW_MV_RST    = 14'd4500;
  localparam logic [BEEP_W-1:0]  BEEP_HALF_RST = 16'd250;

  // Edit limits and steps
  localparam int MIN_PULSE_LO = 400;
  localparam int MIN_PULSE_HI = 1500;
  localparam int MAX_PULSE_LO = 1500;
  localparam int MAX_PULSE_HI = 2600;
  localparam int LIMIT_LO     = 100;
  localparam int LIMIT_HI     = 5000;
  localparam int PULSE_STEP   = 10;
  localparam int LIMIT_STEP   = 50;

  // State reset values
  localparam logic [ANGLE_W-1:0] ANGLE_RST     = 8'd90;
  localparam logic [MINP_W-1:0]  MIN_PULSE_RST = 11'd500;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 12'd2500;
  localparam logic [ANGLE_W-1:0] CENTER_RST    = 8'd90;
  localparam logic [LIMIT_W-1:0] LIMIT_RST     = 13'd800;

  typedef enum logic [2:0] {
    MODE_MENU     = 3'd0,
    MODE_MANUAL   = 3'd1,
    MODE_SWEEP    = 3'd2,
    MODE_CENTER   = 3'd3,
    MODE_SETTINGS = 3'd4
  } mode_t;

  // Settings fields
  localparam logic [CURSOR_W-1:0] FIELD_MIN    = 3'd0;
  localparam logic [CURSOR_W-1:0] FIELD_MAX    = 3'd1;
  localparam logic [CURSOR_W-1:0] FIELD_CENTER = 3'd2;
  localparam logic [CURSOR_W-1:0] FIELD_LIMIT  = 3'd3;
  localparam logic [CURSOR_W-1:0] FIELD_DONE   = 3'd4;

  // Pipeline layout
  localparam int FRONT_STAGES = 6;
  localparam int STATE_STAGE  = FRONT_STAGES;
  localparam int PULSE_STAGES = 2;
  localparam int NUM_STAGES   = FRONT_STAGES + 1 + PULSE_STAGES;

  // Sweep phase: time mod period by reciprocal multiply (exact for 32-bit time)
  localparam int SWEEP_PERIOD = 2 * SWEEP_HALF_MS;
  localparam int PER_LOG      = $clog2(SWEEP_PERIOD);
  localparam int SW_SHIFT     = TIME_W + PER_LOG;
  localparam logic [63:0] SW_RCP =
    ((64'd1 << SW_SHIFT) + 64'(SWEEP_PERIOD) - 64'd1) / 64'(SWEEP_PERIOD);
  localparam int SW_RCP_W    = 34;
  localparam int SW_RCP_HI_W = SW_RCP_W - 16;
  localparam logic [15:0]            SW_RCP_LO = SW_RCP[15:0];
  localparam logic [SW_RCP_HI_W-1:0] SW_RCP_HI = SW_RCP[SW_RCP_W-1:16];
  localparam int SW_Q_W = TIME_W + 1 - PER_LOG;
  localparam int PH_W   = PER_LOG;
  localparam logic [TIME_W-1:0] SW_PERIOD_U = TIME_W'(SWEEP_PERIOD);
  localparam logic [PH_W-1:0]   SW_HALF_PH  = PH_W'(SWEEP_HALF_MS);

  // Sweep angle: (u * MAX_ANGLE) / half by reciprocal multiply
  localparam int SW_V_W     = $clog2(SWEEP_HALF_MS * MAX_ANGLE + 1);
  localparam int SW_A_SHIFT = SW_V_W + $clog2(SWEEP_HALF_MS);
  localparam int SW_A_RCP_W = SW_V_W + 2;
  localparam logic [63:0] SW_A_RCP =
    ((64'd1 << SW_A_SHIFT) + 64'(SWEEP_HALF_MS) - 64'd1) / 64'(SWEEP_HALF_MS);
  localparam logic [SW_A_RCP_W-1:0] SW_A_RCP_K = SW_A_RCP[SW_A_RCP_W-1:0];
  localparam logic [SW_V_W-1:0]     SW_MAX_V   = SW_V_W'(MAX_ANGLE);
  localparam logic [ANGLE_W-1:0]    ANGLE_MAX_U = ANGLE_W'(MAX_ANGLE);

  // Pulse: (angle * span) / MAX_ANGLE by reciprocal multiply
  localparam int SPAN_MAX  = MAX_PULSE_HI - MIN_PULSE_LO;
  localparam int SPAN_W    = $clog2(SPAN_MAX + 1);
  localparam int PR_W      = $clog2(MAX_ANGLE * SPAN_MAX + 1);
  localparam int PR_SHIFT  = PR_W + $clog2(MAX_ANGLE);
  localparam int PR_RCP_W  = PR_W + 2;
  localparam logic [63:0] PR_RCP =
    ((64'd1 << PR_SHIFT) + 64'(MAX_ANGLE) - 64'd1) / 64'(MAX_ANGLE);
  localparam logic [PR_RCP_W-1:0] PR_RCP_K = PR_RCP[PR_RCP_W-1:0];

  typedef struct packed {
    logic [SCALE_W-1:0] mv_scale;
    logic [MV_W-1:0]    low_mv;
    logic [BEEP_W-1:0]  beep_half;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic                      btn;
    logic [TIME_W-1:0]         time_ms;
    logic signed [CUR_W-1:0]   current;
    logic [MV_W-1:0]           mv;
    logic [ANGLE_W-1:0]        sweep_angle;
  } front_beat_t;

  typedef struct packed {
    mode_t               mode;
    logic [ANGLE_W-1:0]  angle;
    logic [CURSOR_W-1:0] cursor;
    logic                alarm;
    logic                buzzer;
    logic [MV_W-1:0]     mv;
    logic                save;
    logic [MINP_W-1:0]   min_pulse;
    logic [PULSE_W-1:0]  max_pulse;
    logic [ANGLE_W-1:0]  center;
    logic [LIMIT_W-1:0]  limit;
  } state_beat_t;

  typedef struct packed {
    state_beat_t        st;
    logic [PULSE_W-1:0] pulse;
  } result_t;

endpackage

`default_nettype wire

// ----- design/servo_tester_mode_controller_top.sv -----
// Servo tester mode controller, top level. Uses stmc_pkg, stmc_front, stmc_state, stmc_pulse.
// A result beat moves through stage registers 0 to 8. Throughput: one frame per cycle while
// out_ready does not stall the output; nine pipeline stages, each with its own valid bit, set
// by the reciprocal multiplies for the sweep phase and the pulse divide.
// Reset (rst, synchronous, active high) empties the pipeline, holds in_ready low, restores
// mode state and loads the configuration registers with their defaults.
`default_nettype none

module servo_tester_mode_controller_top
  import stmc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [DELTA_W-1:0]   encoder_delta,
  input  wire logic                        button_press,
  input  wire logic [TIME_W-1:0]           time_ms,
  input  wire logic [RAW_W-1:0]            vsense_raw,
  input  wire logic signed [CUR_W-1:0]     current_ma,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [2:0]                       mode_now,
  output logic [PULSE_W-1:0]               pulse_us,
  output logic [ANGLE_W-1:0]               shown_angle,
  output logic [CURSOR_W-1:0]              cursor,
  output logic                             alarm,
  output logic                             buzzer,
  output logic [MV_W-1:0]                  voltage_mv,
  output logic                             save_strobe,
  output logic [MINP_W-1:0]                min_pulse_us,
  output logic [PULSE_W-1:0]               max_pulse_us,
  output logic [ANGLE_W-1:0]               center_setting,
  output logic [LIMIT_W-1:0]               current_limit_ma,
  // configuration write port
  input  wire logic                        cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;
  logic                  commit;
  cfg_regs_t             cfg;
  front_beat_t           front_beat;
  state_beat_t           state_beat;
  result_t               res;

  // A stage loads when it is empty or its contents move on this cycle,
  // so bubbles close up while the output beat waits.
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  // Hold off input beats while reset is asserted.
  assign in_ready = en[0] && !rst;
  assign commit   = en[STATE_STAGE] && vld[STATE_STAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Configuration registers; the user must write them only while the pipeline is idle (not enforced here).
  // Indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mv_scale  <= MV_SCALE_RST;
      cfg.low_mv    <= LOW_MV_RST;
      cfg.beep_half <= BEEP_HALF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MV_SCALE:  cfg.mv_scale  <= cfg_data;
        CFG_LOW_MV:    cfg.low_mv    <= cfg_data[MV_W-1:0];
        CFG_BEEP_HALF: cfg.beep_half <= cfg_data[BEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Stages 0-5: capture, voltage, sweep angle
  stmc_front u_front (
    .clk           (clk),
    .en            (en[FRONT_STAGES-1:0]),
    .encoder_delta (encoder_delta),
    .button_press  (button_press),
    .time_ms       (time_ms),
    .vsense_raw    (vsense_raw),
    .current_ma    (current_ma),
    .cfg           (cfg),
    .beat          (front_beat)
  );

  // Stage 6: mode state, edits, alarm and beeper
  stmc_state u_state (
    .clk    (clk),
    .rst    (rst),
    .en     (en[STATE_STAGE]),
    .commit (commit),
    .beat   (front_beat),
    .cfg    (cfg),
    .res    (state_beat)
  );

  // Stages 7-8: pulse width; stage 8 is the output register
  stmc_pulse u_pulse (
    .clk (clk),
    .en  (en[NUM_STAGES-1:STATE_STAGE+1]),
    .st  (state_beat),
    .res (res)
  );

  assign out_valid        = vld[NUM_STAGES-1];
  assign mode_now         = res.st.mode;
  assign pulse_us         = res.pulse;
  assign shown_angle      = res.st.angle;
  assign cursor           = res.st.cursor;
  assign alarm            = res.st.alarm;
  assign buzzer           = res.st.buzzer;
  assign voltage_mv       = res.st.mv;
  assign save_strobe      = res.st.save;
  assign min_pulse_us     = res.st.min_pulse;
  assign max_pulse_us     = res.st.max_pulse;
  assign center_setting   = res.st.center;
  assign current_limit_ma = res.st.limit;

endmodule

`default_nettype wire

// ----- design/stmc_front.sv -----
// Front pipeline: input register, supply voltage and sweep angle.
// Depends on stmc_pkg.
`default_nettype none

module stmc_front
  import stmc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic [FRONT_STAGES-1:0]     en,
  input  wire logic signed [DELTA_W-1:0]   encoder_delta,
  input  wire logic                        button_press,
  input  wire logic [TIME_W-1:0]           time_ms,
  input  wire logic [RAW_W-1:0]            vsense_raw,
  input  wire logic signed [CUR_W-1:0]     current_ma,
  input  wire cfg_regs_t                   cfg,
  output front_beat_t                      beat
);

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic                      btn;
    logic [TIME_W-1:0]         time_ms;
    logic signed [CUR_W-1:0]   current;
  } carry_t;

  carry_t c0, c1, c2, c3, c4;
  logic [RAW_W-1:0]  raw0;
  logic [MV_W-1:0]   mv1, mv2, mv3, mv4;
  logic [47:0]       pa1;
  logic [49:0]       pb1;
  logic [SW_Q_W-1:0] q2;
  logic [PH_W-1:0]   ph3;
  logic [SW_V_W-1:0] v4;
  logic              second4;

  logic [RAW_W+SCALE_W-1:0]   mv_prod;
  logic [65:0]                ph_sum;
  logic [TIME_W-1:0]          ph_full;
  logic [PH_W-1:0]            u_sel;
  logic [2*SW_V_W+1:0]        a_prod;
  logic [ANGLE_W-1:0]         a_quot;

  assign mv_prod = (RAW_W+SCALE_W)'(raw0) * (RAW_W+SCALE_W)'(cfg.mv_scale);
  assign ph_sum  = 66'(pa1) + {pb1, 16'b0};
  assign ph_full = c2.time_ms - TIME_W'(q2) * SW_PERIOD_U;
  assign u_sel   = (ph3 >= SW_HALF_PH) ? (ph3 - SW_HALF_PH) : ph3;
  assign a_prod  = {{SW_A_RCP_W{1'b0}}, v4} * {{SW_V_W{1'b0}}, SW_A_RCP_K};
  assign a_quot  = ANGLE_W'(a_prod >> SW_A_SHIFT);

  // Stage 0: capture the beat
  always_ff @(posedge clk) begin
    if (en[0]) begin
      c0.delta   <= encoder_delta;
      c0.btn     <= button_press;
      c0.time_ms <= time_ms;
      c0.current <= current_ma;
      raw0       <= vsense_raw;
    end
  end

  // Stage 1: voltage (top bits of a Q16 product never pass full scale),
  // partial products of the phase reciprocal
  always_ff @(posedge clk) begin
    if (en[1]) begin
      c1  <= c0;
      mv1 <= mv_prod[RAW_W+SCALE_W-1:16];
      pa1 <= 48'(c0.time_ms) * 48'(SW_RCP_LO);
      pb1 <= 50'(c0.time_ms) * 50'(SW_RCP_HI);
    end
  end

  // Stage 2: period count
  always_ff @(posedge clk) begin
    if (en[2]) begin
      c2  <= c1;
      mv2 <= mv1;
      q2  <= SW_Q_W'(ph_sum >> SW_SHIFT);
    end
  end

  // Stage 3: phase within the period
  always_ff @(posedge clk) begin
    if (en[3]) begin
      c3  <= c2;
      mv3 <= mv2;
      ph3 <= PH_W'(ph_full);
    end
  end

  // Stage 4: fold into one half and scale by the full angle
  always_ff @(posedge clk) begin
    if (en[4]) begin
      c4      <= c3;
      mv4     <= mv3;
      second4 <= (ph3 >= SW_HALF_PH);
      v4      <= SW_V_W'(u_sel) * SW_MAX_V;
    end
  end

  // Stage 5: divide by the half period; fall back down in the second half
  always_ff @(posedge clk) begin
    if (en[5]) begin
      beat.delta       <= c4.delta;
      beat.btn         <= c4.btn;
      beat.time_ms     <= c4.time_ms;
      beat.current     <= c4.current;
      beat.mv          <= mv4;
      beat.sweep_angle <= second4 ? (ANGLE_MAX_U - a_quot) : a_quot;
    end
  end

endmodule

`default_nettype wire

// ----- design/stmc_state.sv -----
// Mode controller state stage: encoder edits, button, alarm and beeper.
// Holds all per-frame state; depends on stmc_pkg.
`default_nettype none

module stmc_state
  import stmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        commit,
  input  wire front_beat_t beat,
  input  wire cfg_regs_t   cfg,
  output state_beat_t      res
);

  localparam logic signed [9:0]  ANG_MAX_S = 10'(MAX_ANGLE);
  localparam logic signed [12:0] MINP_LO_S = 13'(MIN_PULSE_LO);
  localparam logic signed [12:0] MINP_HI_S = 13'(MIN_PULSE_HI);
  localparam logic signed [12:0] MAXP_LO_S = 13'(MAX_PULSE_LO);
  localparam logic signed [12:0] MAXP_HI_S = 13'(MAX_PULSE_HI);
  localparam logic signed [13:0] LIM_LO_S  = 14'(LIMIT_LO);
  localparam logic signed [13:0] LIM_HI_S  = 14'(LIMIT_HI);
  localparam logic signed [12:0] PSTEP_S   = 13'(PULSE_STEP);
  localparam logic signed [13:0] LSTEP_S   = 14'(LIMIT_STEP);

  mode_t               mode, mode_next;
  logic [1:0]          menu_pos, menu_next;
  logic [CURSOR_W-1:0] field_pos, field_next;
  logic [ANGLE_W-1:0]  angle_reg, angle_next;
  logic [MINP_W-1:0]   min_pulse_reg, min_pulse_next;
  logic [PULSE_W-1:0]  max_pulse_reg, max_pulse_next;
  logic [ANGLE_W-1:0]  center_reg, center_next;
  logic [LIMIT_W-1:0]  limit_reg, limit_next;
  logic [TIME_W-1:0]   last_beep_ms, last_beep_next;
  logic                beep_level, beep_next;
  logic                save, alarm;

  logic signed [5:0]  d6, menu_sum;
  logic signed [9:0]  d10, angle_sum, center_sum;
  logic signed [12:0] d13, min_sum, max_sum;
  logic signed [13:0] d14, limit_sum;
  logic [1:0]         menu_clamp;
  logic [ANGLE_W-1:0] angle_clamp, center_clamp;
  logic [MINP_W-1:0]  min_clamp;
  logic [PULSE_W-1:0] max_clamp;
  logic [LIMIT_W-1:0] limit_clamp;
  logic [TIME_W-1:0]  elapsed;

  assign d6  = {beat.delta[DELTA_W-1], beat.delta};
  assign d10 = {{5{beat.delta[DELTA_W-1]}}, beat.delta};
  assign d13 = {{8{beat.delta[DELTA_W-1]}}, beat.delta};
  assign d14 = {{9{beat.delta[DELTA_W-1]}}, beat.delta};

  assign menu_sum   = $signed({4'b0, menu_pos}) + d6;
  assign angle_sum  = $signed({2'b0, angle_reg}) + d10;
  assign center_sum = $signed({2'b0, center_reg}) + d10;
  assign min_sum    = $signed({2'b0, min_pulse_reg}) + d13 * PSTEP_S;
  assign max_sum    = $signed({1'b0, max_pulse_reg}) + d13 * PSTEP_S;
  assign limit_sum  = $signed({1'b0, limit_reg}) + d14 * LSTEP_S;

  // Clamp every edit to its own limits
  assign menu_clamp   = (menu_sum < 6'sd0) ? 2'd0 :
                        (menu_sum > 6'sd3) ? 2'd3 : menu_sum[1:0];
  assign angle_clamp  = (angle_sum < 10'sd0) ? '0 :
                        (angle_sum > ANG_MAX_S) ? ANGLE_MAX_U : angle_sum[ANGLE_W-1:0];
  assign center_clamp = (center_sum < 10'sd0) ? '0 :
                        (center_sum > ANG_MAX_S) ? ANGLE_MAX_U : center_sum[ANGLE_W-1:0];
  assign min_clamp    = (min_sum < MINP_LO_S) ? MINP_W'(MIN_PULSE_LO) :
                        (min_sum > MINP_HI_S) ? MINP_W'(MIN_PULSE_HI) :
                        min_sum[MINP_W-1:0];
  assign max_clamp    = (max_sum < MAXP_LO_S) ? PULSE_W'(MAX_PULSE_LO) :
                        (max_sum > MAXP_HI_S) ? PULSE_W'(MAX_PULSE_HI) :
                        max_sum[PULSE_W-1:0];
  assign limit_clamp  = (limit_sum < LIM_LO_S) ? LIMIT_W'(LIMIT_LO) :
                        (limit_sum > LIM_HI_S) ? LIMIT_W'(LIMIT_HI) :
                        limit_sum[LIMIT_W-1:0];

  assign elapsed = beat.time_ms - last_beep_ms;

  always_comb begin
    mode_next      = mode;
    menu_next      = menu_pos;
    field_next     = field_pos;
    angle_next     = angle_reg;
    min_pulse_next = min_pulse_reg;
    max_pulse_next = max_pulse_reg;
    center_next    = center_reg;
    limit_next     = limit_reg;
    last_beep_next = last_beep_ms;
    beep_next      = beep_level;
    save           = 1'b0;

    // Encoder first, against the mode before the button
    if (beat.delta != '0) begin
      unique case (mode)
        MODE_MENU:   menu_next  = menu_clamp;
        MODE_MANUAL: angle_next = angle_clamp;
        MODE_SETTINGS: begin
          unique case (field_pos)
            FIELD_MIN:    min_pulse_next = min_clamp;
            FIELD_MAX:    max_pulse_next = max_clamp;
            FIELD_CENTER: center_next    = center_clamp;
            default:      limit_next     = limit_clamp;
          endcase
        end
        default: ;
      endcase
    end

    // Button: enter a mode, step a field, or drop back to the menu
    if (beat.btn) begin
      unique case (mode)
        MODE_MENU: begin
          mode_next = mode_t'(3'({1'b0, menu_next}) + 3'd1);
          if (mode_next == MODE_SETTINGS) begin
            field_next = FIELD_MIN;
          end
        end
        MODE_SETTINGS: begin
          field_next = field_pos + 3'd1;
          if (field_next >= FIELD_DONE) begin
            save      = 1'b1;
            mode_next = MODE_MENU;
          end
        end
        default: mode_next = MODE_MENU;
      endcase
    end

    alarm = ($signed({beat.current[CUR_W-1], beat.current}) > $signed({1'b0, limit_next}))
            || (beat.mv < cfg.low_mv);

    if (alarm) begin
      if (elapsed > TIME_W'(cfg.beep_half)) begin
        last_beep_next = beat.time_ms;
        beep_next      = ~beep_level;
      end
    end else begin
      beep_next = 1'b0;
    end

    if (mode_next == MODE_CENTER) begin
      angle_next = center_next;
    end else if (mode_next == MODE_SWEEP) begin
      angle_next = beat.sweep_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_MENU;
      menu_pos      <= '0;
      field_pos     <= FIELD_MIN;
      angle_reg     <= ANGLE_RST;
      min_pulse_reg <= MIN_PULSE_RST;
      max_pulse_reg <= MAX_PULSE_RST;
      center_reg    <= CENTER_RST;
      limit_reg     <= LIMIT_RST;
      last_beep_ms  <= '0;
      beep_level    <= 1'b0;
    end else if (commit) begin
      mode          <= mode_next;
      menu_pos      <= menu_next;
      field_pos     <= field_next;
      angle_reg     <= angle_next;
      min_pulse_reg <= min_pulse_next;
      max_pulse_reg <= max_pulse_next;
      center_reg    <= center_next;
      limit_reg     <= limit_next;
      last_beep_ms  <= last_beep_next;
      beep_level    <= beep_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.mode      <= mode_next;
      res.angle     <= angle_next;
      res.cursor    <= (mode_next == MODE_MENU) ? {1'b0, menu_next} : field_next;
      res.alarm     <= alarm;
      res.buzzer    <= beep_next;
      res.mv        <= beat.mv;
      res.save      <= save;
      res.min_pulse <= min_pulse_next;
      res.max_pulse <= max_pulse_next;
      res.center    <= center_next;
      res.limit     <= limit_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/stmc_pulse.sv -----
// Pulse width stages: angle times span, then divide by the full angle.
// Depends on stmc_pkg.
`default_nettype none

module stmc_pulse
  import stmc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic [PULSE_STAGES-1:0] en,
  input  wire state_beat_t             st,
  output result_t                      res
);

  state_beat_t              st7;
  logic [PR_W-1:0]          prod7;
  logic [SPAN_W-1:0]        span;
  logic [PR_W+PR_RCP_W-1:0] q_prod;
  logic [SPAN_W-1:0]        quot;

  assign span   = SPAN_W'(st.max_pulse - PULSE_W'(st.min_pulse));
  assign q_prod = {{PR_RCP_W{1'b0}}, prod7} * {{PR_W{1'b0}}, PR_RCP_K};
  assign quot   = SPAN_W'(q_prod >> PR_SHIFT);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st7   <= st;
      prod7 <= PR_W'(st.angle) * PR_W'(span);
    end
  end

  // Menu does not drive the servo
  always_ff @(posedge clk) begin
    if (en[1]) begin
      res.st    <= st7;
      res.pulse <= (st7.mode == MODE_MENU) ? '0 :
                   PULSE_W'(st7.min_pulse) + PULSE_W'(quot);
    end
  end

endmodule

`default_nettype wire

// ----- verif/servo_tester_mode_controller_top_test.sv -----
// Self-checking bench for servo_tester_mode_controller_top: directed script, then random frames.
// Depends on stmc_pkg and the design sources; a local predictor gives the expected result beats.
module servo_tester_mode_controller_top_test;
  import stmc_pkg::*;

  // Clock and reset; reset stays high until the stimulus releases it.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  // Block ports; the inputs are at known values from time zero.
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [DELTA_W-1:0]  encoder_delta = '0;
  logic                       button_press = 1'b0;
  logic [TIME_W-1:0]          time_ms = '0;
  logic [RAW_W-1:0]           vsense_raw = '0;
  logic signed [CUR_W-1:0]    current_ma = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [2:0]                 mode_now;
  logic [PULSE_W-1:0]         pulse_us;
  logic [ANGLE_W-1:0]         shown_angle;
  logic [CURSOR_W-1:0]        cursor;
  logic                       alarm;
  logic                       buzzer;
  logic [MV_W-1:0]            voltage_mv;
  logic                       save_strobe;
  logic [MINP_W-1:0]          min_pulse_us;
  logic [PULSE_W-1:0]         max_pulse_us;
  logic [ANGLE_W-1:0]         center_setting;
  logic [LIMIT_W-1:0]         current_limit_ma;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  servo_tester_mode_controller_top uut (
    .clk, .rst,
    .in_valid, .in_ready, .encoder_delta, .button_press, .time_ms, .vsense_raw, .current_ma,
    .out_valid, .out_ready, .mode_now, .pulse_us, .shown_angle, .cursor, .alarm, .buzzer,
    .voltage_mv, .save_strobe, .min_pulse_us, .max_pulse_us, .center_setting,
    .current_limit_ma,
    .cfg_we, .cfg_index, .cfg_data
  );

  // One loop frame as it enters the block.
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic                      btn;
    logic [TIME_W-1:0]         t;
    logic [RAW_W-1:0]          raw;
    logic signed [CUR_W-1:0]   cur;
  } frame_t;

  // Everything the block reports for one frame, in port order.
  typedef struct packed {
    logic [2:0]          mode;
    logic [PULSE_W-1:0]  pulse;
    logic [ANGLE_W-1:0]  angle;
    logic [CURSOR_W-1:0] cursor;
    logic                alarm;
    logic                buzzer;
    logic [MV_W-1:0]     mv;
    logic                save;
    logic [MINP_W-1:0]   min_p;
    logic [PULSE_W-1:0]  max_p;
    logic [ANGLE_W-1:0]  center;
    logic [LIMIT_W-1:0]  limit;
  } panel_t;

  // Directed script row: the frame, then optional hand-computed values for the
  // fields that are obvious from the reset state (pin = 1 means use them).
  typedef struct packed {
    int        delta;
    int        btn;
    bit [31:0] t;
    int        raw;
    int        cur;
    int        pin;
    int        mode;
    int        pulse;
    int        angle;
    int        cursor;
    int        alarm;
    int        mv;
    int        save;
  } script_row_t;

  localparam int SCRIPT_LEN = 22;
  localparam int PHASES     = 6;
  localparam int PER_PHASE  = 305;

  // Walk the menu, hit cursor and voltage extremes, visit every mode, edit every
  // settings field (min, max and limit into their clamps), finish settings with a save, and cross the
  // 32-bit time wrap while the beeper runs.
  //  delta btn  time          raw   cur   pin mode           pulse ang cur al  mv   sv
  script_row_t script [SCRIPT_LEN] = '{
    '{  0, 0, 0,            4095,     0, 1, MODE_MENU,        0,  90, 0, 0, 6600, 0},
    '{-16, 0, 10,              0,     0, 1, MODE_MENU,        0,  90, 0, 1,    0, 0},
    '{ 15, 0, 300,          4095,   801, 1, MODE_MENU,        0,  90, 3, 1, 6600, 0},
    '{  0, 0, 0,            2800,   800, 1, MODE_MENU,        0,  90, 3, 0, 4512, 0},
    '{  0, 0, 32'hFFFF_FFFF, 2790, -3200, 0, 0,               0,   0, 0, 0,    0, 0},
    '{  0, 0, 5,            2790,     0, 0, 0,                0,   0, 0, 0,    0, 0},
    '{ -3, 1, 20,           4095,     0, 1, MODE_MANUAL,   1500,  90, 0, 0, 6600, 0},
    '{ 15, 1, 40,           4095,     0, 1, MODE_MENU,        0, 105, 0, 0, 6600, 0},
    '{  1, 1, 1500,         4095,     0, 1, MODE_SWEEP,    2500, 180, 0, 0, 6600, 0},
    '{-16, 0, 3000,         4095,     0, 1, MODE_SWEEP,     500,   0, 0, 0, 6600, 0},
    '{  0, 0, 4499,         4095,     0, 0, 0,                0,   0, 0, 0,    0, 0},
    '{  0, 1, 4520,         4095,     0, 1, MODE_MENU,        0, 179, 1, 0, 6600, 0},
    '{  1, 1, 4540,         4095,     0, 1, MODE_CENTER,   1500,  90, 0, 0, 6600, 0},
    '{  0, 1, 4560,         4095,     0, 0, 0,                0,   0, 0, 0,    0, 0},
    '{  1, 1, 4580,         4095,     0, 1, MODE_SETTINGS, 1500,  90, 0, 0, 6600, 0},
    '{-16, 0, 4600,         4095,     0, 0, 0,                0,   0, 0, 0,    0, 0},
    '{ 15, 1, 4620,         4095,     0, 0, 0,                0,   0, 0, 0,    0, 0},
    '{ 15, 1, 4640,         4095,     0, 0, 0,                0,   0, 0, 0,    0, 0},
    '{-16, 1, 4660,         4095,     0, 0, 0,                0,   0, 0, 0,    0, 0},
    '{-16, 1, 4680,         4095,   101, 1, MODE_MENU,        0,  90, 3, 1, 6600, 1},
    '{ 15, 1, 4700,         4095,  3200, 0, 0,                0,   0, 0, 0,    0, 0},
    '{ 15, 0, 4720,            0,    -1, 0, 0,                0,   0, 0, 0,    0, 0}
  };

  // Predictor copy of the controller state, starting from reset values.
  mode_t               mode_s    = MODE_MENU;
  logic [1:0]          menu_s    = '0;
  logic [CURSOR_W-1:0] field_s   = FIELD_MIN;
  logic [ANGLE_W-1:0]  angle_s   = ANGLE_RST;
  logic [MINP_W-1:0]   minp_s    = MIN_PULSE_RST;
  logic [PULSE_W-1:0]  maxp_s    = MAX_PULSE_RST;
  logic [ANGLE_W-1:0]  center_s  = CENTER_RST;
  logic [LIMIT_W-1:0]  limit_s   = LIMIT_RST;
  logic [TIME_W-1:0]   beep_at_s = '0;
  logic                beep_s    = 1'b0;
  // Predictor copy of the configuration registers.
  logic [SCALE_W-1:0]  scale_c = MV_SCALE_RST;
  logic [MV_W-1:0]     low_c   = LOW_MV_RST;
  logic [BEEP_W-1:0]   half_c  = BEEP_HALF_RST;

  panel_t awaited [$];   // predicted panels, oldest first

  int faults = 0;
  int checked = 0;
  int frames_sent = 0;
  int settings_loaded = 0;
  int saves_seen = 0;
  int alarms_seen = 0;
  int mode_seen [5] = '{0, 0, 0, 0, 0};
  int send_style = 0;
  int send_left = 0;

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Idle draw per beat: style 0 never idles, 1 draws its idle uniformly, 2 idles rarely.
  function automatic int draw_wait(int style);
    case (style)
      0: return 0;
      1: return $urandom_range(0, 11);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
    endcase
  endfunction

  // Advance the controller by one frame and return what it should report.
  // Order: encoder edit, button, voltage and alarm, beeper, then drive angle and pulse.
  function automatic panel_t run_frame(frame_t f);
    int       d, cur, ph, a;
    longint   mvl;
    logic     alarm_now, save_now;
    panel_t   v;
    d = int'(f.delta);
    cur = int'(f.cur);
    save_now = 1'b0;

    if (d != 0) begin
      case (mode_s)
        MODE_MENU:   menu_s = 2'(clip(int'(menu_s) + d, 0, 3));
        MODE_MANUAL: angle_s = ANGLE_W'(clip(int'(angle_s) + d, 0, MAX_ANGLE));
        MODE_SETTINGS: begin
          case (field_s)
            FIELD_MIN: minp_s = MINP_W'(clip(int'(minp_s) + d * PULSE_STEP,
                                             MIN_PULSE_LO, MIN_PULSE_HI));
            FIELD_MAX: maxp_s = PULSE_W'(clip(int'(maxp_s) + d * PULSE_STEP,
                                              MAX_PULSE_LO, MAX_PULSE_HI));
            FIELD_CENTER: center_s = ANGLE_W'(clip(int'(center_s) + d, 0, MAX_ANGLE));
            default: limit_s = LIMIT_W'(clip(int'(limit_s) + d * LIMIT_STEP,
                                             LIMIT_LO, LIMIT_HI));
          endcase
        end
        default: ;
      endcase
    end

    if (f.btn) begin
      case (mode_s)
        MODE_MENU: begin
          mode_s = mode_t'(3'(menu_s) + 3'd1);
          if (mode_s == MODE_SETTINGS) field_s = FIELD_MIN;
        end
        MODE_SETTINGS: begin
          field_s = field_s + 3'd1;
          if (field_s >= FIELD_DONE) begin
            save_now = 1'b1;
            mode_s = MODE_MENU;
          end
        end
        default: mode_s = MODE_MENU;
      endcase
    end

    mvl = (longint'(f.raw) * longint'(scale_c)) >>> 16;
    if (mvl > 16383) mvl = 16383;
    alarm_now = (cur > int'(limit_s)) || (mvl < longint'(low_c));

    if (alarm_now) begin
      if ((f.t - beep_at_s) > TIME_W'(half_c)) begin
        beep_at_s = f.t;
        beep_s = ~beep_s;
      end
    end else begin
      beep_s = 1'b0;
    end

    if (mode_s == MODE_CENTER) begin
      angle_s = center_s;
    end else if (mode_s == MODE_SWEEP) begin
      ph = int'(f.t % TIME_W'(2 * SWEEP_HALF_MS));
      if (ph < SWEEP_HALF_MS) a = ph * MAX_ANGLE / SWEEP_HALF_MS;
      else a = MAX_ANGLE - (ph - SWEEP_HALF_MS) * MAX_ANGLE / SWEEP_HALF_MS;
      angle_s = ANGLE_W'(a);
    end

    v.mode   = mode_s;
    v.pulse  = (mode_s == MODE_MENU) ? '0 :
               PULSE_W'(int'(minp_s) + int'(angle_s) * (int'(maxp_s) - int'(minp_s)) / MAX_ANGLE);
    v.angle  = angle_s;
    v.cursor = (mode_s == MODE_MENU) ? CURSOR_W'(menu_s) : field_s;
    v.alarm  = alarm_now;
    v.buzzer = beep_s;
    v.mv     = MV_W'(mvl);
    v.save   = save_now;
    v.min_p  = minp_s;
    v.max_p  = maxp_s;
    v.center = center_s;
    v.limit  = limit_s;
    return v;
  endfunction

  function automatic string describe(panel_t v);
    return $sformatf({"mode=%0d pulse=%0d angle=%0d cursor=%0d alarm=%0d buzzer=%0d ",
                      "mv=%0d save=%0d min=%0d max=%0d center=%0d limit=%0d"},
                     v.mode, v.pulse, v.angle, v.cursor, v.alarm, v.buzzer,
                     v.mv, v.save, v.min_p, v.max_p, v.center, v.limit);
  endfunction

  // Send one frame. Called and returning at a falling edge. Idle for a drawn number
  // of cycles first, then hold valid and the payload until the beat is taken, and
  // record the predicted panel at the edge where it moves. When pin is set, the
  // hand-written fields of the script replace the predicted ones.
  task automatic push_frame(input frame_t f, input bit pin, input panel_t pinned);
    int     gap;
    panel_t want;
    if (send_left == 0) begin
      send_style = $urandom_range(0, 2);
      send_left = $urandom_range(30, 120);
    end
    send_left--;
    gap = draw_wait(send_style);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    encoder_delta <= f.delta;
    button_press  <= f.btn;
    time_ms       <= f.t;
    vsense_raw    <= f.raw;
    current_ma    <= f.cur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = run_frame(f);
    if (pin) begin
      want.mode   = pinned.mode;
      want.pulse  = pinned.pulse;
      want.angle  = pinned.angle;
      want.cursor = pinned.cursor;
      want.alarm  = pinned.alarm;
      want.mv     = pinned.mv;
      want.save   = pinned.save;
    end
    awaited.push_back(want);
    frames_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait for every predicted beat to come out, then let the
  // pipeline settle for the number of cycles given by extra.
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Load all three configuration registers, one write per cycle, and mirror
  // them in the predictor. Only called with the pipeline empty.
  task automatic apply_settings(input int scale, input int low_mv, input int half_ms);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MV_SCALE;
    cfg_data  <= CFG_DATA_W'(scale);
    scale_c   = SCALE_W'(scale);
    @(negedge clk);
    cfg_index <= CFG_LOW_MV;
    cfg_data  <= CFG_DATA_W'(low_mv);
    low_c     = MV_W'(low_mv);
    @(negedge clk);
    cfg_index <= CFG_BEEP_HALF;
    cfg_data  <= CFG_DATA_W'(half_ms);
    half_c    = BEEP_W'(half_ms);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
    @(negedge clk);
  endtask

  // Result side: stall a drawn number of cycles per beat, with the style redrawn
  // every few dozen beats so runs without any back-pressure occur too.
  initial begin : sink
    int stall, left, take_style;
    left = 0;
    take_style = 0;
    @(negedge clk);
    forever begin
      if (left == 0) begin
        take_style = $urandom_range(0, 2);
        left = $urandom_range(30, 120);
      end
      left--;
      stall = draw_wait(take_style);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare every result beat with the oldest prediction, field by field.
  always @(posedge clk) begin : check_beat
    panel_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{mode_now, pulse_us, shown_angle, cursor, alarm, buzzer, voltage_mv, save_strobe,
              min_pulse_us, max_pulse_us, center_setting, current_limit_ma};
      if (awaited.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result beat: %s", describe(got));
      end else begin
        want = awaited.pop_front();
        checked++;
        if (got !== want) begin
          faults++;
          if (faults <= 10)
            $display("mismatch on result %0d\n  expected %s\n  actual   %s",
                     checked, describe(want), describe(got));
        end
        if (got.mode <= 3'd4) mode_seen[got.mode]++;
        if (got.save) saves_seen++;
        if (got.alarm) alarms_seen++;
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    frame_t    f;
    panel_t    pinned;
    bit [31:0] clock_ms;
    int        ph, n, i, tmp, lean, btn_pct, ep_left;
    longint    th;

    clock_ms = '0;
    ep_left = 0;
    lean = 0;
    btn_pct = 10;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed script.
    for (i = 0; i < SCRIPT_LEN; i++) begin
      f.delta = DELTA_W'(script[i].delta);
      f.btn   = script[i].btn[0];
      f.t     = script[i].t;
      f.raw   = RAW_W'(script[i].raw);
      f.cur   = CUR_W'(script[i].cur);
      pinned        = '0;
      pinned.mode   = 3'(script[i].mode);
      pinned.pulse  = PULSE_W'(script[i].pulse);
      pinned.angle  = ANGLE_W'(script[i].angle);
      pinned.cursor = CURSOR_W'(script[i].cursor);
      pinned.alarm  = script[i].alarm[0];
      pinned.mv     = MV_W'(script[i].mv);
      pinned.save   = script[i].save[0];
      push_frame(f, script[i].pin[0], pinned);
    end

    // Random phases, each under its own register setting. Phase 0 keeps the
    // reset values; the others cover both extremes, random, typical and a
    // return to the defaults by explicit writes.
    for (ph = 0; ph < PHASES; ph++) begin
      drain(12);
      case (ph)
        1: apply_settings(262143, 13200, 1);
        2: apply_settings(0, 0, 65535);
        3: apply_settings($urandom_range(0, 262143), $urandom_range(0, 13200),
                          $urandom_range(1, 65535));
        4: apply_settings($urandom_range(90000, 120000), $urandom_range(3000, 6000),
                          $urandom_range(1, 600));
        5: apply_settings(int'(MV_SCALE_RST), int'(LOW_MV_RST), int'(BEEP_HALF_RST));
        default: ;
      endcase

      for (n = 0; n < PER_PHASE; n++) begin
        // Redraw the episode: which way the knob leans and how often the button
        // goes, so edits run into their clamps and every mode gets visited.
        if (ep_left == 0) begin
          ep_left = $urandom_range(10, 60);
          lean = $urandom_range(0, 3);
          case ($urandom_range(0, 2))
            0: btn_pct = 4;
            1: btn_pct = 15;
            default: btn_pct = 35;
          endcase
        end
        ep_left--;

        case (lean)
          0: f.delta = DELTA_W'($urandom_range(0, 31));
          1: f.delta = DELTA_W'($urandom_range(0, 15));
          2: begin
            tmp = $urandom_range(0, 16);
            f.delta = DELTA_W'(-tmp);
          end
          default: begin
            tmp = 0;
            if ($urandom_range(0, 3) == 0) tmp = ($urandom_range(0, 1) != 0) ? 1 : -1;
            f.delta = DELTA_W'(tmp);
          end
        endcase
        f.btn = ($urandom_range(0, 99) < btn_pct);

        // Time mostly runs forward like a real loop; jump now and then to any
        // value or to just below the wrap.
        tmp = $urandom_range(0, 99);
        if (tmp == 0) clock_ms = $urandom();
        else if (tmp == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
        else clock_ms = clock_ms + $urandom_range(0, 60);
        f.t = clock_ms;

        // Supply sample: a quarter of frames sit on the low-voltage threshold.
        if ($urandom_range(0, 3) == 0) begin
          th = (scale_c != 0) ? (longint'(low_c) << 16) / longint'(scale_c) : 0;
          if (th > 4095) th = 4095;
          tmp = $urandom_range(0, 8);
          f.raw = RAW_W'(clip(int'(th) + tmp - 4, 0, 4095));
        end else begin
          f.raw = RAW_W'($urandom());
        end

        // Current: a quarter of frames sit on the overcurrent limit.
        if ($urandom_range(0, 3) == 0) begin
          tmp = $urandom_range(0, 6);
          tmp = clip(int'(limit_s) + tmp - 3, -3200, 3200);
        end else begin
          tmp = $urandom_range(0, 6400);
          tmp = tmp - 3200;
        end
        f.cur = CUR_W'(tmp);

        push_frame(f, 1'b0, '0);
      end
    end

    drain(16);
    $display("checked %0d of %0d frames under %0d register loads; frames per mode %0d/%0d/%0d/%0d/%0d",
             checked, frames_sent, settings_loaded, mode_seen[0], mode_seen[1], mode_seen[2],
             mode_seen[3], mode_seen[4]);
    $display("saw %0d save strobes and %0d alarm frames, %0d faults",
             saves_seen, alarms_seen, faults);
    if (faults == 0 && awaited.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
